/* design/lzssd_pkg.sv */
// Shared types and constants of the LZSS window decompressor.
package lzssd_pkg;

   localparam int WINDOW_BYTES_DEF = 4096;
   localparam int QUEUE_DEPTH_DEF  = 4;

   localparam int POS_W     = 12;
   localparam int LEN_W     = 4;
   localparam int LEN_CNT_W = 5;
   localparam int FLAG_IDX_W = 3;

   localparam logic [POS_W-1:0]      START_POS = 12'hFEE;
   localparam int                    MIN_MATCH = 3;
   localparam logic [LEN_CNT_W-1:0]  LAST_COPY_OFS = LEN_CNT_W'(MIN_MATCH - 1);
   localparam logic [FLAG_IDX_W-1:0] LAST_FLAG = 3'd7;

   typedef enum logic [1:0] {
      PH_FLAG,
      PH_FIRST,
      PH_SECOND
   } phase_type;

   typedef enum logic [1:0] {
      CMD_LIT,
      CMD_COPY,
      CMD_END
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type     kind;
      logic [7:0]       lit;
      logic [POS_W-1:0] src;
      logic [LEN_W-1:0] len_m3;
      logic             last;
   } cmd_type;

endpackage

/* design/lzssd_req_if.sv */
// Input channel: one compressed byte per item.
interface lzssd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

/* design/lzssd_rsp_if.sv */
// Result channel: one decompressed byte per item.
interface lzssd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_last;

   modport source (output valid, output out_byte, output run_last, input ready);
   modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

/* design/lzss_window_decompressor_core.sv */
// LZSS decompressor with a 4 KB window: one compressed byte in, decoded bytes out.
// Throughput: one result byte per cycle while the result channel is not stalled, set by
// the single window RAM write port; a literal yields one byte, a reference 3 to 18.
// Flag and first reference bytes are taken by the parser and yield no result.
// Reset is synchronous and clears control state only; the window RAM needs no clearing pass.
module lzss_window_decompressor_core
   import lzssd_pkg::*;
#(
   parameter int WINDOW_BYTES = WINDOW_BYTES_DEF,
   parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   lzssd_req_if.sink   req_chan,
   lzssd_rsp_if.source rsp_chan
);

   // The parser turns each accepted item into at most one command: a literal to
   // emit, a reference to expand, or a bare stream end. Items that only load the
   // flag register or hold the first reference byte push nothing, unless they
   // close the stream.
   logic    q_push;
   cmd_type q_cmd_in;
   logic    q_full;
   logic    q_empty;
   logic    q_pop;
   cmd_type q_head;

   lzssd_parser u_parser (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_cmd    (q_cmd_in)
   );

   // The queue lets the parser keep taking bytes while the engine is busy
   // expanding a long reference or waiting on a stalled result channel.
   lzssd_cmd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_cmd_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd_in),
      .pop      (q_pop),
      .head_cmd (q_head),
      .full     (q_full),
      .empty    (q_empty)
   );

   // The engine registers its window read ahead of the write stage, forwards a byte
   // that is being written in the same cycle it is read, and treats positions
   // not yet written in the current stream as zero by comparing against a fill
   // count. A stream end resets the write position and the fill count, which
   // stands in for clearing the window.
   lzssd_engine #(
      .WINDOW_BYTES (WINDOW_BYTES)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (!q_empty),
      .cmd       (q_head),
      .cmd_pop   (q_pop),
      .rsp_chan  (rsp_chan)
   );

`ifndef NO_ASSERTIONS
   // The parser only pushes a command when the queue has room.
   assert property (@(posedge clock) disable iff (reset) !(q_push && q_full))
      else $error("command pushed into a full queue");

   // The engine only retires a command that is present.
   assert property (@(posedge clock) disable iff (reset) !(q_pop && q_empty))
      else $error("command popped from an empty queue");

   // Reset leaves no command queued and no result pending.
   assert property (@(posedge clock) reset |=> (q_empty && !rsp_chan.valid))
      else $error("queue or result register not cleared by reset");
`endif

endmodule

/* design/lzssd_parser.sv */
// Front end: parses flag, literal and reference bytes into engine commands.
module lzssd_parser
   import lzssd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   lzssd_req_if.sink    req_chan,
   input  logic         q_full,
   output logic         q_push,
   output cmd_type      q_cmd
);

   phase_type             phase_ff, phase_in;
   logic [7:0]            flags_ff, flags_in;
   logic [FLAG_IDX_W-1:0] idx_ff, idx_in;
   logic [7:0]            low_ff, low_in;
   logic                  accept;

   assign req_chan.ready = !q_full;
   assign accept = req_chan.valid && !q_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_FLAG;
         idx_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         idx_ff   <= idx_in;
      end
      flags_ff <= flags_in;
      low_ff   <= low_in;
   end

   always_comb begin
      phase_in    = phase_ff;
      flags_in    = flags_ff;
      idx_in      = idx_ff;
      low_in      = low_ff;
      q_push      = 1'b0;
      q_cmd.kind  = CMD_END;
      q_cmd.lit   = req_chan.in_byte;
      q_cmd.src   = {req_chan.in_byte[7:4], low_ff};
      q_cmd.len_m3 = req_chan.in_byte[LEN_W-1:0];
      q_cmd.last  = req_chan.in_last;
      if (accept) begin
         unique case (phase_ff)
            PH_FIRST: begin
               if (flags_ff[idx_ff]) begin
                  q_push     = 1'b1;
                  q_cmd.kind = CMD_LIT;
                  if (idx_ff == LAST_FLAG) begin
                     idx_in   = '0;
                     phase_in = PH_FLAG;
                  end else begin
                     idx_in   = idx_ff + 1'b1;
                     phase_in = PH_FIRST;
                  end
               end else begin
                  low_in   = req_chan.in_byte;
                  phase_in = PH_SECOND;
                  q_push   = req_chan.in_last;
               end
            end
            PH_SECOND: begin
               q_push     = 1'b1;
               q_cmd.kind = CMD_COPY;
               if (idx_ff == LAST_FLAG) begin
                  idx_in   = '0;
                  phase_in = PH_FLAG;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  phase_in = PH_FIRST;
               end
            end
            default: begin
               // The flag phase; the unused phase code is handled the same way.
               flags_in = req_chan.in_byte;
               idx_in   = '0;
               phase_in = PH_FIRST;
               q_push   = req_chan.in_last;
            end
         endcase
         // The end of a stream puts the parser back to its starting point.
         if (req_chan.in_last) begin
            phase_in = PH_FLAG;
            idx_in   = '0;
            flags_in = '0;
            low_in   = '0;
         end
      end
   end

endmodule

/* design/lzssd_cmd_queue.sv */
// Short command queue between the parser and the copy engine.
module lzssd_cmd_queue
   import lzssd_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output cmd_type head_cmd,
   output logic    full,
   output logic    empty
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   cmd_type         slots [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign head_cmd = slots[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

/* design/lzssd_engine.sv */
// Back end: expands commands through the window RAM and drives the result channel.
module lzssd_engine
   import lzssd_pkg::*;
#(
   parameter int WINDOW_BYTES = WINDOW_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        cmd_valid,
   input  cmd_type     cmd,
   output logic        cmd_pop,
   lzssd_rsp_if.source rsp_chan
);

   localparam int AW = $clog2(WINDOW_BYTES);
   localparam logic [AW-1:0] START_ADDR = AW'(START_POS);
   localparam logic [AW:0]   FILL_FULL  = (AW + 1)'(WINDOW_BYTES);

   logic [7:0] window_mem [WINDOW_BYTES];
   logic [7:0] mem_q_ff;

   logic [AW-1:0]        wpos_ff, wpos_in;
   logic [AW:0]          fill_ff, fill_in;
   logic [LEN_CNT_W-1:0] cnt_ff, cnt_in;

   // Write stage
   logic       w_valid_ff, w_valid_in;
   logic       w_lit_ff;
   logic [7:0] w_lit_data_ff;
   logic       w_fwd_hit_ff;
   logic [7:0] w_fwd_data_ff;
   logic       w_ok_ff;
   logic       w_run_last_ff;
   logic       w_end_ff;

   // Result register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff;
   logic       rsp_last_ff;

   logic          out_free, w_fire, stage_free;
   logic [7:0]    w_data;
   logic          is_lit, is_copy, is_end;
   logic          r_go, end_go, rd_en, copy_final;
   logic [AW-1:0] rd_addr, rd_rel;
   logic          fwd_hit, rd_ok;

   assign out_free   = !rsp_valid_ff || rsp_chan.ready;
   assign w_fire     = w_valid_ff && out_free;
   assign stage_free = !w_valid_ff || w_fire;
   assign w_data     = w_lit_ff     ? w_lit_data_ff :
                       w_fwd_hit_ff ? w_fwd_data_ff :
                       w_ok_ff      ? mem_q_ff      : 8'h00;

   assign is_lit  = (cmd.kind == CMD_LIT);
   assign is_copy = (cmd.kind == CMD_COPY);
   assign is_end  = (cmd.kind == CMD_END);

   // A new stream must not read until the stream end has reset the fill count.
   assign r_go   = cmd_valid && !is_end && stage_free && !(w_valid_ff && w_end_ff);
   assign end_go = cmd_valid && is_end && !w_valid_ff;
   assign rd_en  = r_go && is_copy;

   assign rd_addr    = AW'(cmd.src) + AW'(cnt_ff);
   assign rd_rel     = rd_addr - START_ADDR;
   assign copy_final = (cnt_ff == (LEN_CNT_W'(cmd.len_m3) + LAST_COPY_OFS));
   assign fwd_hit    = w_fire && (wpos_ff == rd_addr);
   assign rd_ok      = fwd_hit || ({1'b0, rd_rel} < fill_ff);

   assign cmd_pop = end_go || (r_go && (is_lit || copy_final));

   always_comb begin
      cnt_in = cnt_ff;
      if (rd_en) begin
         cnt_in = copy_final ? '0 : cnt_ff + 1'b1;
      end
   end

   always_comb begin
      wpos_in = wpos_ff;
      fill_in = fill_ff;
      if (w_fire) begin
         wpos_in = wpos_ff + 1'b1;
         fill_in = (fill_ff == FILL_FULL) ? fill_ff : fill_ff + 1'b1;
      end
      if ((w_fire && w_end_ff) || end_go) begin
         wpos_in = START_ADDR;
         fill_in = '0;
      end
   end

   always_comb begin
      w_valid_in = w_valid_ff;
      if (r_go) begin
         w_valid_in = 1'b1;
      end else if (w_fire) begin
         w_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (w_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wpos_ff      <= START_ADDR;
         fill_ff      <= '0;
         cnt_ff       <= '0;
         w_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wpos_ff      <= wpos_in;
         fill_ff      <= fill_in;
         cnt_ff       <= cnt_in;
         w_valid_ff   <= w_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (r_go) begin
         w_lit_ff      <= is_lit;
         w_lit_data_ff <= cmd.lit;
         w_fwd_hit_ff  <= fwd_hit;
         w_fwd_data_ff <= w_data;
         w_ok_ff       <= rd_ok;
         w_run_last_ff <= is_lit || copy_final;
         w_end_ff      <= cmd.last && (is_lit || copy_final);
      end
      if (w_fire) begin
         rsp_byte_ff <= w_data;
         rsp_last_ff <= w_run_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (w_fire) begin
         window_mem[wpos_ff] <= w_data;
      end
      if (rd_en) begin
         mem_q_ff <= window_mem[rd_addr];
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.out_byte = rsp_byte_ff;
   assign rsp_chan.run_last = rsp_last_ff;

endmodule
